FILE: rtl/shared_segment_table_macros.svh
// Assertion macros shared by the table RTL.
// The first form checks an implication in the same cycle, the second in the next cycle.
`ifndef SHARED_SEGMENT_TABLE_MACROS_SVH
`define SHARED_SEGMENT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define SST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SST_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

   // PAGE_BYTES must be a power of two; sizes are rounded up with an add and a mask.
   localparam int SLOTS      = 16;
   localparam int PAGE_BYTES = 4096;
   localparam int COUNT_BITS = 16;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int CMD_W     = 3;
   localparam int STAT_W    = 3;
   localparam int ID_W      = 31;
   localparam int KEY_W     = 64;
   localparam int RSIZE_W   = 32;
   localparam int SIZE_W    = 33;
   localparam int MODE_W    = 9;
   localparam int ATT_OUT_W = 16;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 160;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic CSR_IDX_PRIVATE_KEY = 1'b0;

   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_GET_OR_CREATE = 3'd0;
   localparam cmd_type CMD_LOOKUP        = 3'd1;
   localparam cmd_type CMD_PUT           = 3'd2;
   localparam cmd_type CMD_REMOVE        = 3'd3;
   localparam cmd_type CMD_ATTACH        = 3'd4;
   localparam cmd_type CMD_DETACH        = 3'd5;
   localparam cmd_type CMD_INFO          = 3'd6;

   typedef logic [STAT_W-1:0] status_type;
   localparam status_type STAT_OK       = 3'd0;
   localparam status_type STAT_EXISTS   = 3'd1;
   localparam status_type STAT_BADVAL   = 3'd2;
   localparam status_type STAT_NOTFOUND = 3'd3;
   localparam status_type STAT_NOSLOT   = 3'd4;

   typedef logic [COUNT_BITS-1:0] count_type;
   localparam count_type COUNT_MAX = '1;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] size;
      logic [MODE_W-1:0] mode;
      count_type         ref_cnt;
      count_type         att_cnt;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_EXEC   = 5'b00100,
      S_CREATE = 5'b01000,
      S_FAIL   = 5'b10000
   } state_type;

endpackage

FILE: rtl/shared_segment_table.sv
`timescale 1ns / 1ps
`include "shared_segment_table_macros.svh"

// Table of shared segments with reference and attach counts, one request at a time.
// Requests arrive on the req_ stream: tuser carries the command, tdata the key, size,
// create and exclusive flags, mode and segment id. Each request yields one response
// beat on the rsp_ stream: tuser carries the status, tdata the id, key, size, mode,
// attach count and removed flag. The private key register sits at csr_ byte address 0.
// The block takes one request and drops req_tready until that request is finished.
// Requests that search by key or id walk the slot memory one slot per cycle through a
// single read port and one shared comparator; a hit then updates the slot in S_EXEC,
// a miss ends in S_CREATE for a create and in S_FAIL otherwise. A create rounds the
// size up to whole pages with an add and a mask in the cycle that writes the slot. A
// create with the private key skips the scan, and a request with a bad command goes
// straight to S_FAIL. The next request can be accepted on the edge after its response
// is loaded.
// The response sits in an output register; the next request is accepted while it waits,
// but finishes only once rsp_tready has taken the earlier beat. Reset clears all used
// and removed flags, sets the next id to one and the private key to zero; the table is
// ready in the first cycle after reset.
module shared_segment_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // key[63:0], req_size[95:64], create[96], exclusive[97], perm_mode[106:98],
   // seg_id[137:107], zero fill above
   input  logic [sst_pkg::REQ_DATA_W-1:0]      req_tdata,
   // cmd[2:0]
   input  logic [sst_pkg::CMD_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_id[30:0], out_key[94:31], out_size[127:95], out_mode[136:128],
   // attach_count[152:137], is_removed[153], zero fill above
   output logic [sst_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status[2:0]
   output logic [sst_pkg::STAT_W-1:0]          rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sst_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sst_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sst_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int SLOT_W = sst_pkg::SLOT_W;
   localparam logic [sst_pkg::SIZE_W-1:0] PAGE_MASK = sst_pkg::SIZE_W'(sst_pkg::PAGE_BYTES - 1);
   localparam logic [SLOT_W:0] SLOTS_C = (SLOT_W + 1)'(sst_pkg::SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(sst_pkg::SLOTS - 1);

   function automatic sst_pkg::count_type sat_inc(input sst_pkg::count_type c);
      sat_inc = (c == sst_pkg::COUNT_MAX) ? c : c + 1'b1;
   endfunction

   // Control state.
   sst_pkg::state_type state_ff, state_in;
   logic [sst_pkg::SLOTS-1:0] used_ff, used_in;
   logic [sst_pkg::SLOTS-1:0] removed_ff, removed_in;
   logic [sst_pkg::ID_W-1:0]  next_id_ff, next_id_in;
   logic [sst_pkg::KEY_W-1:0] pkey_ff, pkey_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      chk_ff, chk_in;
   logic [SLOT_W:0]           scan_ff, scan_in;

   // Request payload.
   sst_pkg::cmd_type          cmd_ff, cmd_in;
   logic [sst_pkg::KEY_W-1:0] key_ff, key_in;
   logic [sst_pkg::RSIZE_W-1:0] size_ff, size_in;
   logic                      create_ff, create_in;
   logic                      excl_ff, excl_in;
   logic [sst_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [sst_pkg::ID_W-1:0]  id_ff, id_in;

   // Scan and update datapath.
   logic [SLOT_W-1:0]         chk_slot_ff, chk_slot_in;
   logic [SLOT_W-1:0]         found_ff, found_in;
   sst_pkg::entry_type        ent_ff, ent_in;
   sst_pkg::entry_type        rd_data_ff;
   sst_pkg::status_type       fail_ff, fail_in;

   // Response register.
   sst_pkg::status_type       rs_status_ff, rs_status_in;
   logic [sst_pkg::ID_W-1:0]  rs_id_ff, rs_id_in;
   logic [sst_pkg::KEY_W-1:0] rs_key_ff, rs_key_in;
   logic [sst_pkg::SIZE_W-1:0] rs_size_ff, rs_size_in;
   logic [sst_pkg::MODE_W-1:0] rs_mode_ff, rs_mode_in;
   logic [sst_pkg::ATT_OUT_W-1:0] rs_att_ff, rs_att_in;
   logic                      rs_rem_ff, rs_rem_in;

   // Slot memory.
   sst_pkg::entry_type        seg_mem_ff [sst_pkg::SLOTS];
   logic                      mem_we;
   logic [SLOT_W-1:0]         mem_waddr;
   sst_pkg::entry_type        mem_wdata;
   logic [SLOT_W-1:0]         rd_addr;

   logic                      req_accept;
   logic                      out_free;
   logic                      load_rsp;
   logic                      cmp_eq;
   logic                      hit;
   logic                      live_only;
   logic [sst_pkg::KEY_W-1:0] cmp_lhs, cmp_rhs;
   logic [SLOT_W-1:0]         free_slot;
   logic                      free_any;
   logic [sst_pkg::SIZE_W-1:0] size_up;
   logic [sst_pkg::SIZE_W-1:0] size_rounded;
   sst_pkg::count_type        ref_dec, att_dec;
   logic [31:0]               att_wide;
   logic                      csr_wr;

   assign req_tready = (state_ff == sst_pkg::S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rs_status_ff;
   assign rsp_tdata  = {6'd0, rs_rem_ff, rs_att_ff, rs_mode_ff, rs_size_ff, rs_key_ff, rs_id_ff};

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[sst_pkg::CSR_ADDR_W-1] == sst_pkg::CSR_IDX_PRIVATE_KEY) ?
                       pkey_ff : '0;

   assign rd_addr = scan_ff[SLOT_W-1:0];

   // The one comparator serves both key and id searches.
   always_comb begin
      if (cmd_ff == sst_pkg::CMD_GET_OR_CREATE) begin
         cmp_lhs = rd_data_ff.key;
         cmp_rhs = key_ff;
      end else begin
         cmp_lhs = sst_pkg::KEY_W'(rd_data_ff.id);
         cmp_rhs = sst_pkg::KEY_W'(id_ff);
      end
      cmp_eq    = (cmp_lhs == cmp_rhs);
      live_only = (cmd_ff == sst_pkg::CMD_GET_OR_CREATE) || (cmd_ff == sst_pkg::CMD_LOOKUP);
      hit       = chk_ff && used_ff[chk_slot_ff] && cmp_eq &&
                  !(live_only && removed_ff[chk_slot_ff]);
   end

   always_comb begin
      free_slot = '0;
      for (int i = sst_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
      free_any = !(&used_ff);
   end

   // The page size is a power of two, so rounding up to whole pages is an add and a mask.
   always_comb begin
      size_up      = sst_pkg::SIZE_W'(size_ff) + PAGE_MASK;
      size_rounded = size_up & ~PAGE_MASK;
   end

   always_comb begin
      ref_dec  = ent_ff.ref_cnt - 1'b1;
      att_dec  = (ent_ff.att_cnt != '0) ? ent_ff.att_cnt - 1'b1 : ent_ff.att_cnt;
      att_wide = 32'(ent_ff.att_cnt);
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      removed_in   = removed_ff;
      next_id_in   = next_id_ff;
      pkey_in      = pkey_ff;
      chk_in       = 1'b0;
      scan_in      = scan_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      size_in      = size_ff;
      create_in    = create_ff;
      excl_in      = excl_ff;
      mode_in      = mode_ff;
      id_in        = id_ff;
      chk_slot_in  = chk_slot_ff;
      found_in     = found_ff;
      ent_in       = ent_ff;
      fail_in      = fail_ff;
      load_rsp     = 1'b0;
      rs_status_in = sst_pkg::STAT_OK;
      rs_id_in     = '0;
      rs_key_in    = '0;
      rs_size_in   = '0;
      rs_mode_in   = '0;
      rs_att_in    = '0;
      rs_rem_in    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = found_ff;
      mem_wdata    = ent_ff;

      if (csr_wr && (csr_paddr[sst_pkg::CSR_ADDR_W-1] == sst_pkg::CSR_IDX_PRIVATE_KEY)) begin
         pkey_in = csr_pwdata;
      end

      case (state_ff)
         sst_pkg::S_IDLE: begin
            if (req_accept) begin
               cmd_in     = req_tuser;
               key_in     = req_tdata[63:0];
               size_in    = req_tdata[95:64];
               create_in  = req_tdata[96];
               excl_in    = req_tdata[97];
               mode_in    = req_tdata[106:98];
               id_in      = req_tdata[137:107];
               scan_in    = '0;
               case (req_tuser)
                  sst_pkg::CMD_GET_OR_CREATE: begin
                     state_in = (req_tdata[63:0] == pkey_ff) ? sst_pkg::S_CREATE :
                                                               sst_pkg::S_SCAN;
                  end
                  sst_pkg::CMD_LOOKUP, sst_pkg::CMD_PUT, sst_pkg::CMD_REMOVE,
                  sst_pkg::CMD_ATTACH, sst_pkg::CMD_DETACH, sst_pkg::CMD_INFO: begin
                     state_in = sst_pkg::S_SCAN;
                  end
                  default: begin
                     fail_in  = sst_pkg::STAT_BADVAL;
                     state_in = sst_pkg::S_FAIL;
                  end
               endcase
            end
         end

         sst_pkg::S_SCAN: begin
            // A read is issued each cycle; its data is checked in the next cycle.
            if (scan_ff < SLOTS_C) begin
               chk_in      = 1'b1;
               chk_slot_in = scan_ff[SLOT_W-1:0];
               scan_in     = scan_ff + 1'b1;
            end
            if (hit) begin
               chk_in   = 1'b0;
               found_in = chk_slot_ff;
               ent_in   = rd_data_ff;
               state_in = sst_pkg::S_EXEC;
            end else if (chk_ff && (chk_slot_ff == LAST_SLOT)) begin
               chk_in = 1'b0;
               if ((cmd_ff == sst_pkg::CMD_GET_OR_CREATE) && create_ff) begin
                  state_in = sst_pkg::S_CREATE;
               end else begin
                  fail_in  = sst_pkg::STAT_NOTFOUND;
                  state_in = sst_pkg::S_FAIL;
               end
            end
         end

         sst_pkg::S_EXEC: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = sst_pkg::S_IDLE;
               case (cmd_ff)
                  sst_pkg::CMD_GET_OR_CREATE: begin
                     if (create_ff && excl_ff) begin
                        rs_status_in = sst_pkg::STAT_EXISTS;
                     end else if (sst_pkg::SIZE_W'(size_ff) > ent_ff.size) begin
                        rs_status_in = sst_pkg::STAT_BADVAL;
                     end else begin
                        mem_we            = 1'b1;
                        mem_wdata.ref_cnt = sat_inc(ent_ff.ref_cnt);
                        rs_id_in          = ent_ff.id;
                     end
                  end
                  sst_pkg::CMD_LOOKUP: begin
                     mem_we            = 1'b1;
                     mem_wdata.ref_cnt = sat_inc(ent_ff.ref_cnt);
                     rs_id_in          = ent_ff.id;
                  end
                  sst_pkg::CMD_PUT: begin
                     if (ent_ff.ref_cnt != '0) begin
                        mem_we            = 1'b1;
                        mem_wdata.ref_cnt = ref_dec;
                        if (removed_ff[found_ff] && (ref_dec == '0) &&
                            (ent_ff.att_cnt == '0)) begin
                           used_in[found_ff]    = 1'b0;
                           removed_in[found_ff] = 1'b0;
                        end
                     end
                  end
                  sst_pkg::CMD_REMOVE: begin
                     if (removed_ff[found_ff]) begin
                        rs_status_in = sst_pkg::STAT_NOTFOUND;
                     end else if ((ent_ff.ref_cnt == '0) && (ent_ff.att_cnt == '0)) begin
                        used_in[found_ff]    = 1'b0;
                        removed_in[found_ff] = 1'b0;
                     end else begin
                        removed_in[found_ff] = 1'b1;
                     end
                  end
                  sst_pkg::CMD_ATTACH: begin
                     mem_we            = 1'b1;
                     mem_wdata.att_cnt = sat_inc(ent_ff.att_cnt);
                  end
                  sst_pkg::CMD_DETACH: begin
                     mem_we            = 1'b1;
                     mem_wdata.att_cnt = att_dec;
                     if (removed_ff[found_ff] && (ent_ff.ref_cnt == '0) && (att_dec == '0)) begin
                        used_in[found_ff]    = 1'b0;
                        removed_in[found_ff] = 1'b0;
                     end
                  end
                  sst_pkg::CMD_INFO: begin
                     rs_id_in   = ent_ff.id;
                     rs_key_in  = ent_ff.key;
                     rs_size_in = ent_ff.size;
                     rs_mode_in = ent_ff.mode;
                     rs_att_in  = att_wide[sst_pkg::ATT_OUT_W-1:0];
                     rs_rem_in  = removed_ff[found_ff];
                  end
                  default: begin
                     rs_status_in = sst_pkg::STAT_BADVAL;
                  end
               endcase
            end
         end

         sst_pkg::S_CREATE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = sst_pkg::S_IDLE;
               if (size_ff == '0) begin
                  rs_status_in = sst_pkg::STAT_BADVAL;
               end else if (!free_any) begin
                  rs_status_in = sst_pkg::STAT_NOSLOT;
               end else begin
                  mem_we                = 1'b1;
                  mem_waddr             = free_slot;
                  mem_wdata.id          = next_id_ff;
                  mem_wdata.key         = key_ff;
                  mem_wdata.size        = size_rounded;
                  mem_wdata.mode        = mode_ff;
                  mem_wdata.ref_cnt     = sst_pkg::COUNT_BITS'(1);
                  mem_wdata.att_cnt     = '0;
                  used_in[free_slot]    = 1'b1;
                  removed_in[free_slot] = 1'b0;
                  rs_id_in              = next_id_ff;
                  // Ids skip zero when they wrap.
                  next_id_in = (&next_id_ff) ? sst_pkg::ID_W'(1) : next_id_ff + 1'b1;
               end
            end
         end

         sst_pkg::S_FAIL: begin
            if (out_free) begin
               load_rsp     = 1'b1;
               rs_status_in = fail_ff;
               state_in     = sst_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sst_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::S_IDLE;
         used_ff      <= '0;
         removed_ff   <= '0;
         next_id_ff   <= sst_pkg::ID_W'(1);
         pkey_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         chk_ff       <= 1'b0;
         scan_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         removed_ff   <= removed_in;
         next_id_ff   <= next_id_in;
         pkey_ff      <= pkey_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_ff       <= chk_in;
         scan_ff      <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      size_ff     <= size_in;
      create_ff   <= create_in;
      excl_ff     <= excl_in;
      mode_ff     <= mode_in;
      id_ff       <= id_in;
      chk_slot_ff <= chk_slot_in;
      found_ff    <= found_in;
      ent_ff      <= ent_in;
      fail_ff     <= fail_in;
      if (load_rsp) begin
         rs_status_ff <= rs_status_in;
         rs_id_ff     <= rs_id_in;
         rs_key_ff    <= rs_key_in;
         rs_size_ff   <= rs_size_in;
         rs_mode_ff   <= rs_mode_in;
         rs_att_ff    <= rs_att_in;
         rs_rem_ff    <= rs_rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seg_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= seg_mem_ff[rd_addr];
   end

   `SST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_tready, "request accepted while busy")
   `SST_ASSERT_NOW(a_found_slot_used, clock, reset, state_ff == sst_pkg::S_EXEC, used_ff[found_ff], "update on a free slot")
   `SST_ASSERT_NEXT(a_create_marks_used, clock, reset, (state_ff == sst_pkg::S_CREATE) && mem_we, used_ff[$past(free_slot)] && !removed_ff[$past(free_slot)], "created slot not live")
   `SST_ASSERT_NOW(a_next_id_nonzero, clock, reset, 1'b1, next_id_ff != '0, "next id is zero")

endmodule
